FILE: design/hbcc_pkg.sv
package hbcc_pkg;

	// Defaults for the top-level parameters
	localparam int MaxVolumeDefault  = 15;
	localparam int CountWidthDefault = 16;

	localparam int NumLanes   = 4;
	localparam int NumFrames  = 6;
	localparam int CfgWidth   = 16;
	localparam int VolWidth   = 4;

	localparam logic [CfgWidth-1:0] DebounceReset = 16'd50;

	// Lane order, which is also the event order
	localparam int LanePower   = 0;
	localparam int LaneVolUp   = 1;
	localparam int LaneVolDown = 2;
	localparam int LaneMute    = 3;

	// Frame delimiters and command codes
	localparam logic [7:0] FrameStart   = 8'hFF;
	localparam logic [7:0] FrameEnd     = 8'hFE;
	localparam logic [7:0] CmdPower     = 8'h00;
	localparam logic [7:0] CmdVolume    = 8'h01;
	localparam logic [7:0] CmdVolDown   = 8'h02;
	localparam logic [7:0] CmdMute      = 8'h03;
	localparam logic [7:0] CmdAudioOn   = 8'h04;
	localparam logic [7:0] DataOn       = 8'h01;

	// Byte position inside one four-byte frame
	typedef enum logic [1:0] {
		BYTE_SOF,
		BYTE_CMD,
		BYTE_DATA,
		BYTE_EOF
	} byte_pos_t;

	typedef struct packed {
		logic                mic;
		logic                audio;
		logic                muted;
		logic [VolWidth-1:0] volume;
	} status_t;

	// Everything one tick produces: the frame slots and the final status
	typedef struct packed {
		logic [NumFrames-1:0]       frame_en;
		logic [NumFrames-1:0][7:0]  frame_cmd;
		logic [NumFrames-1:0][7:0]  frame_data;
		status_t                    status;
	} tick_desc_t;

endpackage

FILE: design/headset_button_command_controller_top.sv
// Channel   Dir  Width            Contents
// s_*       in   tdata 8          [0] power, [1] vol up, [2] vol down, [3] mute pressed
// m_*       out  tdata 16, user 1 tx_byte, volume, muted, audio, mic; tuser = byte_valid
// config    in   16 + we          debounce_ticks, written when debounce_we is high
//
// One tick in produces 4*F+1 words out, F = frames fired (0 to 6), so 1 to 25 words.
// The output port moves one word a cycle while m_tready is high; that sets the sustained tick rate.
// The first word of a tick passes through the tick descriptor register, then the serializer registers.
// A tick is taken while the previous one is still streaming out: the tick
// descriptor register holds one tick ahead of the serializer.
// Reset clears counters, audio, mute, mic, sets volume to 8 (or the max if lower)
// and the debounce limit to 50.
module headset_button_command_controller_top import hbcc_pkg::*; #(
	parameter int MAX_VOLUME  = MaxVolumeDefault,
	parameter int COUNT_WIDTH = CountWidthDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,     // power, vol_up, vol_down, mute, zero pad
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [15:0]         m_tdata,     // tx_byte[7:0], volume[11:8], muted,
	                                         // audio_on, mic_on, zero pad
	output logic                m_tuser,     // byte_valid
	output logic                m_tlast,     // last word of the tick (status word)
	input  logic                debounce_we,
	input  logic [CfgWidth-1:0] debounce_ticks
);

	logic [CfgWidth-1:0] debounce_q;
	logic [NumLanes-1:0] fire;
	logic                advance;
	logic                take;
	logic                desc_valid_s1;
	tick_desc_t          desc_s1;

	// Hold the debounce limit; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DebounceReset;
		end else if (debounce_we) begin
			debounce_q <= debounce_ticks;
		end
	end

	// Take a new tick when the descriptor stage is free or drains this cycle
	assign s_tready = !desc_valid_s1 || take;
	assign advance  = s_tvalid && s_tready;

	// One lane per button: counter and fire decision side by side
	for (genvar g = 0; g < NumLanes; g++) begin : g_lane
		hbcc_lane #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.pressed (s_tdata[g]),
			.debounce(debounce_q),
			.fire    (fire[g])
		);
	end

	// Merge lane events in order into state and frame slots
	hbcc_merge #(
		.MAX_VOLUME(MAX_VOLUME)
	) u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.fire         (fire),
		.take         (take),
		.desc_valid_s1(desc_valid_s1),
		.desc_s1      (desc_s1)
	);

	// Stream the frame bytes, then the status word
	hbcc_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.desc_valid(desc_valid_s1),
		.desc      (desc_s1),
		.take      (take),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

FILE: design/hbcc_lane.sv
module hbcc_lane import hbcc_pkg::*; #(
	parameter int COUNT_WIDTH = CountWidthDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic                pressed,
	input  logic [CfgWidth-1:0] debounce,
	output logic                fire
);

	localparam int CmpWidth = (COUNT_WIDTH > CfgWidth) ? COUNT_WIDTH : CfgWidth;

	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] count_inc;

	// Count first (saturating), then compare against the limit
	assign count_inc = (&count_q) ? count_q : count_q + 1'b1;
	assign fire      = pressed &&
		(CmpWidth'(count_inc) > CmpWidth'(debounce));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (advance) begin
			count_q <= fire ? '0 : count_inc;
		end
	end

endmodule

FILE: design/hbcc_merge.sv
module hbcc_merge import hbcc_pkg::*; #(
	parameter int MAX_VOLUME = MaxVolumeDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [NumLanes-1:0] fire,
	input  logic                take,
	output logic                desc_valid_s1,
	output tick_desc_t          desc_s1
);

	localparam logic [VolWidth-1:0] VolMax   = VolWidth'(MAX_VOLUME);
	localparam logic [VolWidth-1:0] VolReset =
		(MAX_VOLUME < 8) ? VolWidth'(MAX_VOLUME) : VolWidth'(8);

	logic [VolWidth-1:0] volume_q;
	logic                mute_q;
	logic                audio_q;
	logic                mic_q;

	logic [VolWidth-1:0] vol_a, vol_b;
	logic                audio_n, mic_a, mic_n, mute_n;
	tick_desc_t          desc_n;

	// Apply the lanes' events in order: power, volume up, volume down, mute
	always_comb begin
		desc_n            = '0;
		desc_n.frame_cmd  = '0;
		desc_n.frame_data = '0;

		audio_n = audio_q;
		mic_a   = mic_q;
		if (fire[LanePower]) begin
			audio_n = !audio_q;
			if (!audio_q) begin
				desc_n.frame_en[0]   = 1'b1;
				desc_n.frame_cmd[0]  = CmdPower;
				desc_n.frame_data[0] = DataOn;
				desc_n.frame_en[1]   = 1'b1;
				desc_n.frame_cmd[1]  = CmdVolume;
				desc_n.frame_data[1] = 8'(volume_q);
				desc_n.frame_en[2]   = 1'b1;
				desc_n.frame_cmd[2]  = CmdAudioOn;
				desc_n.frame_data[2] = DataOn;
			end else begin
				mic_a = 1'b0;
			end
		end

		vol_a = volume_q;
		if (fire[LaneVolUp] && (volume_q < VolMax)) begin
			vol_a                = volume_q + 1'b1;
			desc_n.frame_en[3]   = audio_n;
			desc_n.frame_cmd[3]  = CmdVolume;
			desc_n.frame_data[3] = 8'(vol_a);
		end

		vol_b = vol_a;
		if (fire[LaneVolDown] && (vol_a != '0)) begin
			vol_b                = vol_a - 1'b1;
			desc_n.frame_en[4]   = audio_n;
			desc_n.frame_cmd[4]  = CmdVolDown;
			desc_n.frame_data[4] = 8'(vol_b);
		end

		mute_n = mute_q;
		mic_n  = mic_a;
		if (fire[LaneMute]) begin
			mute_n               = !mute_q;
			mic_n                = mute_q && audio_n;
			desc_n.frame_en[5]   = audio_n;
			desc_n.frame_cmd[5]  = CmdMute;
			desc_n.frame_data[5] = 8'(mute_n);
		end

		desc_n.status.volume = vol_b;
		desc_n.status.muted  = mute_n;
		desc_n.status.audio  = audio_n;
		desc_n.status.mic    = mic_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q      <= VolReset;
			mute_q        <= 1'b0;
			audio_q       <= 1'b0;
			mic_q         <= 1'b0;
			desc_valid_s1 <= 1'b0;
		end else begin
			if (advance) begin
				volume_q      <= vol_b;
				mute_q        <= mute_n;
				audio_q       <= audio_n;
				mic_q         <= mic_n;
				desc_valid_s1 <= 1'b1;
			end else if (take) begin
				desc_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			desc_s1 <= desc_n;
		end
	end

endmodule

FILE: design/hbcc_serializer.sv
module hbcc_serializer import hbcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        desc_valid,
	input  tick_desc_t  desc,
	output logic        take,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic        m_tuser,
	output logic        m_tlast
);

	logic                      busy_q;
	logic [NumFrames-1:0]      mask_q;
	logic [NumFrames-1:0][7:0] cmd_q;
	logic [NumFrames-1:0][7:0] data_q;
	status_t                   status_q;
	byte_pos_t                 pos_q, pos_n;
	logic [NumFrames-1:0]      mask_n;

	logic [$clog2(NumFrames)-1:0] cur;
	logic                         word_done;
	logic                         tick_done;
	logic [7:0]                   tx_byte;

	assign word_done = busy_q && m_tready;
	assign tick_done = word_done && (mask_q == '0);
	assign take      = desc_valid && (!busy_q || tick_done);

	// Lowest pending frame slot
	always_comb begin
		cur = '0;
		for (int i = NumFrames - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				cur = ($clog2(NumFrames))'(i);
			end
		end
	end

	// Next byte position and pending mask
	always_comb begin
		pos_n  = pos_q;
		mask_n = mask_q;
		if (word_done && (mask_q != '0)) begin
			case (pos_q)
				BYTE_SOF:  pos_n = BYTE_CMD;
				BYTE_CMD:  pos_n = BYTE_DATA;
				BYTE_DATA: pos_n = BYTE_EOF;
				BYTE_EOF: begin
					pos_n  = BYTE_SOF;
					mask_n = mask_q & (mask_q - 1'b1);
				end
				default:   pos_n = BYTE_SOF;
			endcase
		end
	end

	// Output word
	always_comb begin
		tx_byte = '0;
		if (mask_q != '0) begin
			case (pos_q)
				BYTE_SOF:  tx_byte = FrameStart;
				BYTE_CMD:  tx_byte = cmd_q[cur];
				BYTE_DATA: tx_byte = data_q[cur];
				BYTE_EOF:  tx_byte = FrameEnd;
				default:   tx_byte = '0;
			endcase
		end
	end

	assign m_tvalid = busy_q;
	assign m_tuser  = (mask_q != '0);
	assign m_tlast  = (mask_q == '0);
	assign m_tdata  = {1'b0, status_q.mic, status_q.audio, status_q.muted,
		status_q.volume, tx_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mask_q <= '0;
			pos_q  <= BYTE_SOF;
		end else if (take) begin
			busy_q <= 1'b1;
			mask_q <= desc.frame_en;
			pos_q  <= BYTE_SOF;
		end else begin
			if (tick_done) begin
				busy_q <= 1'b0;
			end
			mask_q <= mask_n;
			pos_q  <= pos_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q    <= desc.frame_cmd;
			data_q   <= desc.frame_data;
			status_q <= desc.status;
		end
	end

endmodule

FILE: design/hbcc_checker.sv
module hbcc_checker import hbcc_pkg::*; #(
	parameter int MAX_VOLUME = MaxVolumeDefault
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser != m_tlast))
		else $error("word is both or neither frame byte and status");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tdata[7:0] == 8'h00))
		else $error("status word carries a byte");

	a_volume: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[11:8] <= VolWidth'(MAX_VOLUME)))
		else $error("volume above maximum");

	a_mic: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[14] |-> (m_tdata[13] && !m_tdata[12]))
		else $error("mic on while muted or audio off");

endmodule

bind headset_button_command_controller_top hbcc_checker #(
	.MAX_VOLUME(MAX_VOLUME)
) u_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);
